>>> src/arpe_pkg.sv
// ----------------------------------------------------------------------------
// arpe_pkg: shared types and constants of the angular reprojection error block
// widths, fixed-point constants, register indexes, cordic angle table
// ----------------------------------------------------------------------------
package arpe_pkg;

  localparam int unsigned SQRT_CELLS   = 32;
  localparam int unsigned SQRT2_FIRST  = 3;
  localparam int unsigned DIV_CELLS    = 15;
  localparam int unsigned CORDIC_CELLS = 20;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [15:0]        HALF_PI_Q14 = 16'd25736;
  localparam logic [15:0]        PI_Q14      = 16'd51472;
  localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;

  typedef enum logic [2:0] {
    REG_ROT_A  = 3'd0,
    REG_ROT_B  = 3'd1,
    REG_ROT_C  = 3'd2,
    REG_TRANS_X = 3'd3,
    REG_TRANS_Y = 3'd4,
    REG_TRANS_Z = 3'd5,
    REG_LIMIT  = 3'd6
  } cfg_idx_e;

  // data that rides along a chain of cells
  typedef struct packed {
    logic                   zero;
    logic [2:0][15:0]       bear;
    logic [2:0][31:0]       cam;
  } side_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] step);
    logic [29:0] v;
    unique case (step)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/arpe_sqrt_cell.sv
// ----------------------------------------------------------------------------
// arpe_sqrt_cell: one digit of a pipelined integer square root
// resolves one root bit per cell and hands radicand, root and sideband on
// ----------------------------------------------------------------------------
module arpe_sqrt_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [4:0]            step_i,
  input  logic                  valid_i,
  input  logic [63:0]           rad_i,
  input  logic [63:0]           root_i,
  input  arpe_pkg::side_t       side_i,
  output logic                  valid_o,
  output logic [63:0]           rad_o,
  output logic [63:0]           root_o,
  output arpe_pkg::side_t       side_o
);

  logic [5:0]  shift;
  logic [63:0] bit_val;
  logic [63:0] trial;
  logic [63:0] rad_d, root_d, rad_q, root_q;
  logic        valid_q;
  arpe_pkg::side_t side_q;

  always_comb begin
    shift   = 6'd62 - {step_i, 1'b0};
    bit_val = 64'd1 << shift;
    trial   = root_i + bit_val;
    if (rad_i >= trial) begin
      rad_d  = rad_i - trial;
      root_d = (root_i >> 1) + bit_val;
    end else begin
      rad_d  = rad_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

>>> src/arpe_div_cell.sv
// ----------------------------------------------------------------------------
// arpe_div_cell: one quotient bit of three restoring dividers by the norm
// the three lanes share the divisor and the sideband
// ----------------------------------------------------------------------------
module arpe_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [3:0]            step_i,
  input  logic                  valid_i,
  input  logic [2:0][46:0]      rem_i,
  input  logic [2:0][14:0]      quo_i,
  input  logic [31:0]           norm_i,
  input  arpe_pkg::side_t       side_i,
  output logic                  valid_o,
  output logic [2:0][46:0]      rem_o,
  output logic [2:0][14:0]      quo_o,
  output logic [31:0]           norm_o,
  output arpe_pkg::side_t       side_o
);

  logic [46:0]      dvs;
  logic [2:0][46:0] rem_d, rem_q;
  logic [2:0][14:0] quo_d, quo_q;
  logic [31:0]      norm_q;
  logic             valid_q;
  arpe_pkg::side_t  side_q;

  always_comb begin
    dvs = {15'd0, norm_i} << step_i;
    for (int i = 0; i < 3; i++) begin
      if (rem_i[i] >= dvs) begin
        rem_d[i] = rem_i[i] - dvs;
        quo_d[i] = {quo_i[i][13:0], 1'b1};
      end else begin
        rem_d[i] = rem_i[i];
        quo_d[i] = {quo_i[i][13:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      norm_q <= norm_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign norm_o  = norm_q;
  assign side_o  = side_q;

endmodule

>>> src/arpe_cordic_cell.sv
// ----------------------------------------------------------------------------
// arpe_cordic_cell: one vectoring micro-rotation of the arccosine cordic
// drives y toward zero and accumulates the angle in q2.30
// ----------------------------------------------------------------------------
module arpe_cordic_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [4:0]            step_i,
  input  logic                  valid_i,
  input  logic signed [31:0]    x_i,
  input  logic signed [31:0]    y_i,
  input  logic signed [33:0]    acc_i,
  input  logic                  zero_i,
  output logic                  valid_o,
  output logic signed [31:0]    x_o,
  output logic signed [31:0]    y_o,
  output logic signed [33:0]    acc_o,
  output logic                  zero_o
);

  logic signed [31:0] xs, ys;
  logic signed [33:0] ang;
  logic signed [31:0] x_d, y_d, x_q, y_q;
  logic signed [33:0] acc_d, acc_q;
  logic               valid_q, zero_q;

  always_comb begin
    xs  = x_i >>> step_i;
    ys  = y_i >>> step_i;
    ang = $signed({4'd0, arpe_pkg::atan_q30(step_i)});
    if (y_i > 32'sd0) begin
      x_d   = x_i + ys;
      y_d   = y_i - xs;
      acc_d = acc_i + ang;
    end else begin
      x_d   = x_i - ys;
      y_d   = y_i + xs;
      acc_d = acc_i - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign zero_o  = zero_q;

endmodule

>>> src/angular_reprojection_error.sv
// depth: 107 register stages, from the input registers through the output register
// throughput: one item per cycle; the whole cell chain advances together and
//   holds only while a result sits in the output register and is not taken
// reset: rst_ni clears all valid bits and the pose registers to zero
// ----------------------------------------------------------------------------
// angular_reprojection_error: angle between observed and reprojected bearing
// transform, norm square root, divide, dot product, arccosine by cordic
// ----------------------------------------------------------------------------
module angular_reprojection_error (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [47:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // bear_x, bear_y, bear_z, world_x, world_y, world_z
  input  logic [143:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // angle_err, consistent, zero_point, zero fill
  output logic [23:0]   m_axis_tdata
);

  localparam int unsigned N_SQ2 = arpe_pkg::SQRT_CELLS - arpe_pkg::SQRT2_FIRST;

  logic [2:0][47:0]        rot_q;
  logic [2:0][31:0]        trans_q;
  logic [15:0]             limit_q;
  logic                    en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= '0;
      trans_q <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arpe_pkg::REG_ROT_A:   rot_q[0]   <= cfg_data_i;
        arpe_pkg::REG_ROT_B:   rot_q[1]   <= cfg_data_i;
        arpe_pkg::REG_ROT_C:   rot_q[2]   <= cfg_data_i;
        arpe_pkg::REG_TRANS_X: trans_q[0] <= cfg_data_i[31:0];
        arpe_pkg::REG_TRANS_Y: trans_q[1] <= cfg_data_i[31:0];
        arpe_pkg::REG_TRANS_Z: trans_q[2] <= cfg_data_i[31:0];
        arpe_pkg::REG_LIMIT:   limit_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // difference to camera position
  logic                    v1_q;
  logic [2:0][15:0]        b1_q;
  logic [2:0][31:0]        d1_q, d1_d;
  logic signed [32:0]      diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({s_axis_tdata[48+32*i+31], s_axis_tdata[48+32*i +: 32]})
              - $signed({trans_q[i][31], trans_q[i]});
      if (diff[i][32] != diff[i][31]) begin
        d1_d[i] = diff[i][32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        d1_d[i] = diff[i][31:0];
      end
    end
  end

  // rotation products
  logic                    v2_q;
  logic [2:0][15:0]        b2_q;
  logic signed [47:0]      p2_q [3][3];

  // camera point
  logic                    v3_q, z3_q;
  logic [2:0][15:0]        b3_q;
  logic [2:0][31:0]        c3_q, c3_d;
  logic signed [49:0]      csum [3];
  logic signed [35:0]      csh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = 50'(p2_q[i][0]) + 50'(p2_q[i][1]) + 50'(p2_q[i][2]);
      csh[i]  = csum[i][49:14];
      if (csh[i][35:31] != {5{csh[i][31]}}) begin
        c3_d[i] = csh[i][35] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        c3_d[i] = csh[i][31:0];
      end
    end
  end

  // squares and norm squared
  logic                    v4_q, z4_q, v5_q, z5_q;
  logic [2:0][15:0]        b4_q, b5_q;
  logic [2:0][31:0]        c4_q, c5_q;
  logic [2:0][63:0]        sq4_q;
  logic [63:0]             n5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q <= s_axis_tdata[47:0];
      d1_q <= d1_d;
      b2_q <= b1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2_q[i][j] <= $signed(rot_q[i][16*j +: 16]) * $signed(d1_q[j]);
        end
      end
      b3_q <= b2_q;
      c3_q <= c3_d;
      z3_q <= (c3_d == '0);
      b4_q <= b3_q;
      c4_q <= c3_q;
      z4_q <= z3_q;
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= 64'($signed(c3_q[i]) * $signed(c3_q[i]));
      end
      b5_q <= b4_q;
      c5_q <= c4_q;
      z5_q <= z4_q;
      n5_q <= sq4_q[0] + sq4_q[1] + sq4_q[2];
    end
  end

  // norm square root chain
  logic                    sv   [arpe_pkg::SQRT_CELLS+1];
  logic [63:0]             srad [arpe_pkg::SQRT_CELLS+1];
  logic [63:0]             sroot[arpe_pkg::SQRT_CELLS+1];
  arpe_pkg::side_t         sside[arpe_pkg::SQRT_CELLS+1];

  assign sv[0]    = v5_q;
  assign srad[0]  = n5_q;
  assign sroot[0] = '0;
  assign sside[0] = '{zero: z5_q, bear: b5_q, cam: c5_q};

  for (genvar k = 0; k < arpe_pkg::SQRT_CELLS; k++) begin : g_sqrt
    arpe_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .step_i(5'(k)),
      .valid_i(sv[k]), .rad_i(srad[k]), .root_i(sroot[k]), .side_i(sside[k]),
      .valid_o(sv[k+1]), .rad_o(srad[k+1]), .root_o(sroot[k+1]), .side_o(sside[k+1])
    );
  end

  // divider setup
  logic                    v6_q;
  logic [2:0][46:0]        r6_q;
  logic [31:0]             n6_q;
  arpe_pkg::side_t         side6_q;
  logic [31:0]             mag [3];
  logic [31:0]             norm_w;

  always_comb begin
    norm_w = sroot[arpe_pkg::SQRT_CELLS][31:0];
    for (int i = 0; i < 3; i++) begin
      mag[i] = sside[arpe_pkg::SQRT_CELLS].cam[i][31]
             ? 32'(-sside[arpe_pkg::SQRT_CELLS].cam[i])
             : sside[arpe_pkg::SQRT_CELLS].cam[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= sv[arpe_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n6_q    <= norm_w;
      side6_q <= sside[arpe_pkg::SQRT_CELLS];
      for (int i = 0; i < 3; i++) begin
        r6_q[i] <= {1'b0, mag[i], 14'd0} + {16'd0, norm_w[31:1]};
      end
    end
  end

  // unit bearing dividers
  logic                    dv   [arpe_pkg::DIV_CELLS+1];
  logic [2:0][46:0]        drem [arpe_pkg::DIV_CELLS+1];
  logic [2:0][14:0]        dquo [arpe_pkg::DIV_CELLS+1];
  logic [31:0]             dnorm[arpe_pkg::DIV_CELLS+1];
  arpe_pkg::side_t         dside[arpe_pkg::DIV_CELLS+1];

  assign dv[0]    = v6_q;
  assign drem[0]  = r6_q;
  assign dquo[0]  = '0;
  assign dnorm[0] = n6_q;
  assign dside[0] = side6_q;

  for (genvar k = 0; k < arpe_pkg::DIV_CELLS; k++) begin : g_div
    arpe_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .step_i(4'(arpe_pkg::DIV_CELLS - 1 - k)),
      .valid_i(dv[k]), .rem_i(drem[k]), .quo_i(dquo[k]), .norm_i(dnorm[k]),
      .side_i(dside[k]),
      .valid_o(dv[k+1]), .rem_o(drem[k+1]), .quo_o(dquo[k+1]), .norm_o(dnorm[k+1]),
      .side_o(dside[k+1])
    );
  end

  // dot product with the observed bearing
  logic                    v7_q, z7_q, v8_q, z8_q, v9_q, z9_q;
  logic signed [31:0]      p7_q [3];
  logic signed [15:0]      u7 [3];
  logic signed [33:0]      dsum;
  logic signed [29:0]      dot8_d, dot8_q, dot9_q;
  logic [63:0]             rad9_q;
  logic signed [59:0]      dsq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u7[i] = dside[arpe_pkg::DIV_CELLS].cam[i][31]
            ? -$signed({1'b0, dquo[arpe_pkg::DIV_CELLS][i]})
            : $signed({1'b0, dquo[arpe_pkg::DIV_CELLS][i]});
    end
    dsum = 34'(p7_q[0]) + 34'(p7_q[1]) + 34'(p7_q[2]);
    if (dsum > arpe_pkg::ONE_Q28) begin
      dot8_d = 30'(arpe_pkg::ONE_Q28);
    end else if (dsum < -arpe_pkg::ONE_Q28) begin
      dot8_d = 30'(-arpe_pkg::ONE_Q28);
    end else begin
      dot8_d = dsum[29:0];
    end
    dsq = dot8_q * dot8_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v7_q <= dv[arpe_pkg::DIV_CELLS];
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z7_q <= dside[arpe_pkg::DIV_CELLS].zero;
      for (int i = 0; i < 3; i++) begin
        p7_q[i] <= $signed(dside[arpe_pkg::DIV_CELLS].bear[i]) * u7[i];
      end
      z8_q   <= z7_q;
      dot8_q <= dot8_d;
      z9_q   <= z8_q;
      dot9_q <= dot8_q;
      rad9_q <= (64'd1 << 56) - 64'(dsq);
    end
  end

  // sine term square root chain, dot product rides in cam[0]
  logic                    tv   [N_SQ2+1];
  logic [63:0]             trad [N_SQ2+1];
  logic [63:0]             troot[N_SQ2+1];
  arpe_pkg::side_t         tside[N_SQ2+1];

  assign tv[0]    = v9_q;
  assign trad[0]  = rad9_q;
  assign troot[0] = '0;
  assign tside[0] = '{zero: z9_q, bear: '0, cam: {64'd0, 32'(dot9_q)}};

  for (genvar k = 0; k < N_SQ2; k++) begin : g_sqrt2
    arpe_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .step_i(5'(k + arpe_pkg::SQRT2_FIRST)),
      .valid_i(tv[k]), .rad_i(trad[k]), .root_i(troot[k]), .side_i(tside[k]),
      .valid_o(tv[k+1]), .rad_o(trad[k+1]), .root_o(troot[k+1]), .side_o(tside[k+1])
    );
  end

  // pre-rotation of a negative dot product
  logic                    v10_q, z10_q;
  logic signed [31:0]      x10_q, y10_q;
  logic signed [33:0]      a10_q;
  logic signed [31:0]      dotw, sinw;

  assign dotw = $signed(tside[N_SQ2].cam[0]);
  assign sinw = $signed(troot[N_SQ2][31:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (en) begin
      v10_q <= tv[N_SQ2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z10_q <= tside[N_SQ2].zero;
      if (dotw < 32'sd0) begin
        x10_q <= sinw;
        y10_q <= -dotw;
        a10_q <= arpe_pkg::HALF_PI_Q30;
      end else begin
        x10_q <= dotw;
        y10_q <= sinw;
        a10_q <= '0;
      end
    end
  end

  // cordic chain
  logic                    cv  [arpe_pkg::CORDIC_CELLS+1];
  logic signed [31:0]      cx  [arpe_pkg::CORDIC_CELLS+1];
  logic signed [31:0]      cy  [arpe_pkg::CORDIC_CELLS+1];
  logic signed [33:0]      ca  [arpe_pkg::CORDIC_CELLS+1];
  logic                    cz  [arpe_pkg::CORDIC_CELLS+1];

  assign cv[0] = v10_q;
  assign cx[0] = x10_q;
  assign cy[0] = y10_q;
  assign ca[0] = a10_q;
  assign cz[0] = z10_q;

  for (genvar k = 0; k < arpe_pkg::CORDIC_CELLS; k++) begin : g_cordic
    arpe_cordic_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .step_i(5'(k)),
      .valid_i(cv[k]), .x_i(cx[k]), .y_i(cy[k]), .acc_i(ca[k]), .zero_i(cz[k]),
      .valid_o(cv[k+1]), .x_o(cx[k+1]), .y_o(cy[k+1]), .acc_o(ca[k+1]), .zero_o(cz[k+1])
    );
  end

  // rounding and output register
  logic signed [34:0]      rnd;
  logic [18:0]             ang19;
  logic [15:0]             ang_d, ang_q;
  logic                    zero_q;

  always_comb begin
    rnd   = ca[arpe_pkg::CORDIC_CELLS] < 34'sd0 ? 35'sd32768
          : 35'(ca[arpe_pkg::CORDIC_CELLS]) + 35'sd32768;
    ang19 = rnd[34:16];
    if (cz[arpe_pkg::CORDIC_CELLS]) begin
      ang_d = arpe_pkg::HALF_PI_Q14;
    end else if (ang19 > 19'(arpe_pkg::PI_Q14)) begin
      ang_d = arpe_pkg::PI_Q14;
    end else begin
      ang_d = ang19[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= cv[arpe_pkg::CORDIC_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q  <= ang_d;
      zero_q <= cz[arpe_pkg::CORDIC_CELLS];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, zero_q, (ang_q < limit_q), ang_q};

  a_zero_half_pi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && zero_q |-> ang_q == arpe_pkg::HALF_PI_Q14)
    else $error("zero point without pi/2 angle");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ang_q <= arpe_pkg::PI_Q14)
    else $error("angle above pi");

  a_stall_holds_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v10_q) && $stable(v5_q))
    else $error("chain moved during stall");

  a_zero_cam : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && z4_q |-> sq4_q == '0)
    else $error("zero flag with nonzero camera point");

endmodule
